/* hw/rtl/dcpr_pkg.sv */
// Shared constants, status codes and pipeline word types for depth-to-color registration.
`timescale 1ns / 1ps

package dcpr_pkg;

    // Frame geometry
    localparam int DEPTH_PIXELS = 217088;
    localparam int COLOR_WIDTH  = 1920;
    localparam int COLOR_HEIGHT = 1080;
    localparam int COLOR_BYTES  = COLOR_WIDTH * COLOR_HEIGHT * 3;

    // Field widths
    localparam int SRC_W    = 19;
    localparam int DEPTH_W  = 16;
    localparam int MAP_W    = 32;
    localparam int ROW_W    = 24;
    localparam int OFS_W    = 23;
    localparam int SHIFT_W  = 32;
    localparam int FOCAL_W  = 28;
    localparam int CENTER_W = 28;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Fixed-point layout: map is Q.24, registers Q.16, product Q.40
    localparam int FRAC_MAP   = 24;
    localparam int FRAC_REG   = 16;
    localparam int FRAC_PROD  = FRAC_MAP + FRAC_REG;
    localparam int DVD_SHIFT  = FRAC_MAP - FRAC_REG;
    localparam int DVD_W      = SHIFT_W + DVD_SHIFT;
    localparam int DIV_STAGES = DVD_W / 2;
    localparam int SUM_W      = 35;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SHIFT  = 2'd0;
    localparam logic [1:0] REG_FOCAL  = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_SRC_OUT   = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_COLOR_OUT = 2'd3
    } t_status;

    // Fields that ride along the pipeline with each word
    typedef struct packed {
        logic [DEPTH_W-1:0]       depth;
        logic signed [MAP_W-1:0]  map;
        logic signed [ROW_W-1:0]  row;
        t_status                  code;
    } t_side;

    // Divider working state: partial remainder, dividend bits left, quotient so far
    typedef struct packed {
        logic [DEPTH_W-1:0] rem;
        logic [DVD_W-1:0]   dvd;
        logic [DVD_W-1:0]   quo;
        logic               neg;
    } t_div;

endpackage

/* hw/rtl/dcpr_div_stage.sv */
// One radix-4 restoring division stage: two quotient bits per clock while i_ce is high.
`timescale 1ns / 1ps

module dcpr_div_stage
    import dcpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ce,
    input  logic  i_valid,
    input  t_div  i_div,
    input  t_side i_side,
    output logic  o_valid,
    output t_div  o_div,
    output t_side o_side
);

    logic               r_valid;
    t_div               r_div;
    t_side              r_side;
    t_div               n_div;

    logic [DEPTH_W:0]   w_t1;
    logic [DEPTH_W:0]   w_t2;
    logic [DEPTH_W:0]   w_d1;
    logic [DEPTH_W:0]   w_d2;
    logic               w_q1;
    logic               w_q2;
    logic [DEPTH_W-1:0] w_r1;
    logic [DEPTH_W-1:0] w_r2;

    // Two shift-compare-subtract steps; divisor is the depth sample
    always_comb begin
        w_t1 = {i_div.rem, i_div.dvd[DVD_W-1]};
        w_q1 = (w_t1 >= {1'b0, i_side.depth});
        w_d1 = w_t1 - {1'b0, i_side.depth};
        w_r1 = w_q1 ? w_d1[DEPTH_W-1:0] : w_t1[DEPTH_W-1:0];

        w_t2 = {w_r1, i_div.dvd[DVD_W-2]};
        w_q2 = (w_t2 >= {1'b0, i_side.depth});
        w_d2 = w_t2 - {1'b0, i_side.depth};
        w_r2 = w_q2 ? w_d2[DEPTH_W-1:0] : w_t2[DEPTH_W-1:0];

        n_div.rem = w_r2;
        n_div.dvd = {i_div.dvd[DVD_W-3:0], 2'b00};
        n_div.quo = {i_div.quo[DVD_W-3:0], w_q1, w_q2};
        n_div.neg = i_div.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

/* hw/rtl/dcpr_divider.sv */
// Pipelined divider: shift numerator over depth, one radix-4 stage per clock while i_ce is high.
`timescale 1ns / 1ps

module dcpr_divider
    import dcpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  t_div             i_div,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DVD_W-1:0] o_quo,
    output logic             o_neg,
    output t_side            o_side
);

    logic  w_valid [DIV_STAGES+1];
    t_div  w_div   [DIV_STAGES+1];
    t_side w_side  [DIV_STAGES+1];

    assign w_valid[0] = i_valid;
    assign w_div[0]   = i_div;
    assign w_side[0]  = i_side;

    // Stage chain, most significant quotient bits first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        dcpr_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (i_ce),
            .i_valid (w_valid[k]),
            .i_div   (w_div[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_div   (w_div[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    assign o_valid = w_valid[DIV_STAGES];
    assign o_quo   = w_div[DIV_STAGES].quo;
    assign o_neg   = w_div[DIV_STAGES].neg;
    assign o_side  = w_side[DIV_STAGES];

endmodule

/* hw/rtl/dcpr_project.sv */
// Projection pipeline: shift sum, split multiply, round, column to byte offset, status.
`timescale 1ns / 1ps

module dcpr_project
    import dcpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [DVD_W-1:0]    i_quo,
    input  logic                i_neg,
    input  t_side               i_side,
    input  logic [FOCAL_W-1:0]  i_focal,
    input  logic [CENTER_W-1:0] i_center,
    output logic                o_valid,
    output logic [DEPTH_W-1:0]  o_depth,
    output logic [OFS_W-1:0]    o_offset,
    output t_status             o_status
);

    localparam int EXT_W = DVD_W + 2;             // map + signed quotient
    localparam int LO_W  = 17;                    // low part of the sum, unsigned
    localparam int HI_W  = SUM_W - LO_W;          // high part of the sum, signed
    localparam int PLO_W = LO_W + FOCAL_W;
    localparam int PHI_W = HI_W + FOCAL_W + 1;
    localparam int R_W   = PHI_W + LO_W + 1;
    localparam int COL_W = R_W - FRAC_PROD;
    localparam int OFF_W = COL_W + 3;

    // Stage 1: signed quotient plus map, saturated
    logic signed [DVD_W:0]   w_q;
    logic signed [EXT_W-1:0] w_sum;
    logic signed [SUM_W-1:0] n_s1_sum;
    logic                    r1_valid;
    logic signed [SUM_W-1:0] r1_sum;
    t_side                   r1_side;

    always_comb begin
        w_q   = i_neg ? -$signed({1'b0, i_quo}) : $signed({1'b0, i_quo});
        w_sum = EXT_W'(i_side.map) + EXT_W'(w_q);
        // in range when the sum's sign bit and all bits above it agree
        if (&w_sum[EXT_W-1:SUM_W-1] || ~|w_sum[EXT_W-1:SUM_W-1]) begin
            n_s1_sum = w_sum[SUM_W-1:0];
        end else if (w_sum[EXT_W-1]) begin
            n_s1_sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            n_s1_sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // Stage 2: two partial products of sum times focal length
    logic                    r2_valid;
    logic [PLO_W-1:0]        r2_plo;
    logic signed [PHI_W-1:0] r2_phi;
    t_side                   r2_side;
    logic [PLO_W-1:0]        n_s2_plo;
    logic signed [PHI_W-1:0] n_s2_phi;

    always_comb begin
        n_s2_plo = PLO_W'(r1_sum[LO_W-1:0]) * PLO_W'(i_focal);
        n_s2_phi = PHI_W'($signed(r1_sum[SUM_W-1:LO_W])) * PHI_W'($signed({1'b0, i_focal}));
    end

    // Stage 3: Q.40 position with center and half added
    logic               r3_valid;
    logic [R_W-1:0]     r3_pos;
    t_side              r3_side;
    logic [R_W-1:0]     n_s3_pos;

    always_comb begin
        n_s3_pos = (R_W'(r2_phi) << LO_W) + R_W'(r2_plo)
                 + (R_W'(i_center) << (FRAC_PROD - FRAC_REG))
                 + (R_W'(1) << (FRAC_PROD - 1));
    end

    // Stage 4: integer column, truncated toward zero
    logic                    r4_valid;
    logic signed [COL_W-1:0] r4_col;
    t_side                   r4_side;
    logic signed [COL_W-1:0] n_s4_col;

    always_comb begin
        n_s4_col = $signed(r3_pos[R_W-1:FRAC_PROD])
                 + $signed(COL_W'(r3_pos[R_W-1] && (|r3_pos[FRAC_PROD-1:0])));
    end

    // Stage 5: byte offset, range check, result word
    logic signed [OFF_W-1:0] w_off;
    t_status                 n_status;
    logic [DEPTH_W-1:0]      n_depth;
    logic [OFS_W-1:0]        n_offset;
    logic                    r5_valid;
    logic [DEPTH_W-1:0]      r5_depth;
    logic [OFS_W-1:0]        r5_offset;
    t_status                 r5_status;

    always_comb begin
        w_off = (OFF_W'(r4_col) <<< 1) + OFF_W'(r4_col) + OFF_W'(r4_side.row);
        n_status = r4_side.code;
        if (r4_side.code == ST_VALID) begin
            if (w_off[OFF_W-1] || ($unsigned(w_off) >= OFF_W'(COLOR_BYTES))) begin
                n_status = ST_COLOR_OUT;
            end
        end
        n_depth  = (r4_side.code == ST_SRC_OUT) ? '0 : r4_side.depth;
        n_offset = (n_status == ST_VALID) ? w_off[OFS_W-1:0] : '0;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_sum    <= n_s1_sum;
            r1_side   <= i_side;
            r2_plo    <= n_s2_plo;
            r2_phi    <= n_s2_phi;
            r2_side   <= r1_side;
            r3_pos    <= n_s3_pos;
            r3_side   <= r2_side;
            r4_col    <= n_s4_col;
            r4_side   <= r3_side;
            r5_depth  <= n_depth;
            r5_offset <= n_offset;
            r5_status <= n_status;
        end
    end

    assign o_valid  = r5_valid;
    assign o_depth  = r5_depth;
    assign o_offset = r5_offset;
    assign o_status = r5_status;

endmodule

/* hw/rtl/depth_color_pixel_register.sv */
// Top level: register port, input stage, divider and projection pipeline.
`timescale 1ns / 1ps

// Maps each depth pixel to its byte offset in the color frame. One word per clock is taken
// and one result word per clock is given while the output is not stalled. Each accepted input
// word passes one input register, 20 radix-4 divider stages for shift / depth and five
// projection stages ending in the output register. When m_axis_tready is low with a result
// waiting, the whole pipeline holds and s_axis_tready drops in the same cycle; otherwise
// input is taken every clock. Registers must be written through the APB port only while no
// word is in flight; the block itself does not enforce this.

module depth_color_pixel_register
    import dcpr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [18:0] source_index, [34:19] depth_sample, [66:35] map_column, [90:67] row_offset
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] undistorted_depth, [38:16] color_offset
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]             m_axis_tuser,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Configuration registers
    logic signed [SHIFT_W-1:0] r_shift;
    logic [FOCAL_W-1:0]        r_focal;
    logic [CENTER_W-1:0]       r_center;
    logic [1:0]                w_reg_idx;
    logic                      w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= SHIFT_W'(3407872);
            r_focal  <= FOCAL_W'(70844416);
            r_center <= CENTER_W'(62914560);
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_SHIFT:  r_shift  <= pwdata[SHIFT_W-1:0];
                REG_FOCAL:  r_focal  <= pwdata[FOCAL_W-1:0];
                REG_CENTER: r_center <= pwdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SHIFT:  prdata = APB_DATA_W'($unsigned(r_shift));
            REG_FOCAL:  prdata = APB_DATA_W'(r_focal);
            REG_CENTER: prdata = APB_DATA_W'(r_center);
            default:    prdata = '0;
        endcase
    end

    // Global advance: move when the output register is empty or being taken
    logic w_ce;
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;

    // Input word unpacking and early status
    logic signed [SRC_W-1:0] w_src;
    logic [SHIFT_W-1:0]      w_shift_mag;
    t_side                   n_side;
    t_div                    n_div;

    always_comb begin
        w_src        = s_axis_tdata[SRC_W-1:0];
        n_side.depth = s_axis_tdata[SRC_W +: DEPTH_W];
        n_side.map   = s_axis_tdata[SRC_W+DEPTH_W +: MAP_W];
        n_side.row   = s_axis_tdata[SRC_W+DEPTH_W+MAP_W +: ROW_W];
        if (w_src[SRC_W-1] || ($unsigned(w_src) >= SRC_W'(DEPTH_PIXELS))) begin
            n_side.code = ST_SRC_OUT;
        end else if (n_side.depth == '0) begin
            n_side.code = ST_BAD_DEPTH;
        end else begin
            n_side.code = ST_VALID;
        end
        w_shift_mag = r_shift[SHIFT_W-1] ? -$unsigned(r_shift) : $unsigned(r_shift);
        n_div.rem   = '0;
        n_div.dvd   = {w_shift_mag, {DVD_SHIFT{1'b0}}};
        n_div.quo   = '0;
        n_div.neg   = r_shift[SHIFT_W-1];
    end

    // Input register
    logic  r_in_valid;
    t_side r_in_side;
    t_div  r_in_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_ce) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_in_side <= n_side;
            r_in_div  <= n_div;
        end
    end

    // Divider
    logic             w_dv_valid;
    logic [DVD_W-1:0] w_dv_quo;
    logic             w_dv_neg;
    t_side            w_dv_side;

    dcpr_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_in_valid),
        .i_div   (r_in_div),
        .i_side  (r_in_side),
        .o_valid (w_dv_valid),
        .o_quo   (w_dv_quo),
        .o_neg   (w_dv_neg),
        .o_side  (w_dv_side)
    );

    // Projection and output register
    logic [DEPTH_W-1:0] w_depth;
    logic [OFS_W-1:0]   w_offset;
    t_status            w_status;

    dcpr_project u_project (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (w_ce),
        .i_valid  (w_dv_valid),
        .i_quo    (w_dv_quo),
        .i_neg    (w_dv_neg),
        .i_side   (w_dv_side),
        .i_focal  (r_focal),
        .i_center (r_center),
        .o_valid  (m_axis_tvalid),
        .o_depth  (w_depth),
        .o_offset (w_offset),
        .o_status (w_status)
    );

    assign m_axis_tdata = {1'b0, w_offset, w_depth};
    assign m_axis_tuser = w_status;

endmodule

/* hw/rtl/dcpr_checker.sv */
// Port-level checks on result words, bound to the top level.
`timescale 1ns / 1ps

module dcpr_checker
    import dcpr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // Only a valid status carries a color offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_VALID)) |-> (m_axis_tdata[38:16] == '0))
        else $error("nonzero color offset on a non-valid status");

    // A valid offset lies inside the color frame
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_VALID))
            |-> (m_axis_tdata[38:16] < OFS_W'(COLOR_BYTES)))
        else $error("valid color offset outside the color frame");

    // Source outside the depth frame gives zero depth
    a_src_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_SRC_OUT)) |-> (m_axis_tdata[15:0] == '0))
        else $error("depth nonzero for source outside the depth frame");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result word changed while stalled");

endmodule

bind depth_color_pixel_register dcpr_checker u_dcpr_checker (.*);
